/* hdl/wccm_pkg.sv */
package wccm_pkg;

	// field widths
	localparam int X_W         = 8;
	localparam int COLOR_W     = 15;
	localparam int LAYER_W     = 3;
	localparam int PAL_W       = 3;
	localparam int MASK_W      = 5;
	localparam int CH_W        = 5;
	localparam int CH_COUNT    = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_INDEX_W = 3;

	// window slots: four backgrounds, objects, color window
	localparam int SLOT_COUNT = 6;
	localparam int SLOT_COLOR = 5;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_EDGES        = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_SELECT       = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LOGIC        = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LAYER_ENABLE = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_COLOR_WINDOW_CTRL   = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_COLOR_MATH_CTRL     = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_FIXED_COLOR         = 3'd6;

	// window combine codes
	localparam logic [1:0] LOGIC_OR   = 2'd0;
	localparam logic [1:0] LOGIC_AND  = 2'd1;
	localparam logic [1:0] LOGIC_XOR  = 2'd2;
	localparam logic [1:0] LOGIC_XNOR = 2'd3;

	// region codes
	localparam logic [1:0] REGION_NEVER   = 2'd0;
	localparam logic [1:0] REGION_OUTSIDE = 2'd1;
	localparam logic [1:0] REGION_INSIDE  = 2'd2;
	localparam logic [1:0] REGION_ALWAYS  = 2'd3;

	// layer codes
	localparam logic [LAYER_W-1:0] LAYER_BG_LAST = 3'd3;
	localparam logic [LAYER_W-1:0] LAYER_OBJ     = 3'd4;
	localparam logic [PAL_W-1:0]   PAL_MATH_MIN  = 3'd4;

	localparam logic [CH_W-1:0] CH_MAX = 5'd31;

	typedef struct packed {
		logic [31:0] window_edges;
		logic [23:0] window_select;
		logic [15:0] window_logic;
		logic [15:0] window_layer_enable;
		logic [7:0]  color_window_control;
		logic [7:0]  color_math_control;
		logic [14:0] fixed_color;
	} cfg_t;

	function automatic logic region_active(input logic [1:0] region, input logic inside_win);
		logic act;
		case (region)
			REGION_NEVER:   act = 1'b0;
			REGION_OUTSIDE: act = !inside_win;
			REGION_INSIDE:  act = inside_win;
			default:        act = 1'b1;
		endcase
		return act;
	endfunction

endpackage

/* hdl/wccm_if.sv */
interface wccm_in_if;
	import wccm_pkg::*;

	logic               valid;
	logic               ready;
	logic [X_W-1:0]     pixel_x;
	logic [COLOR_W-1:0] main_color;
	logic [LAYER_W-1:0] main_layer;
	logic [PAL_W-1:0]   main_obj_palette;
	logic [COLOR_W-1:0] sub_color;

	modport source (output valid, pixel_x, main_color, main_layer, main_obj_palette,
		sub_color, input ready);
	modport sink (input valid, pixel_x, main_color, main_layer, main_obj_palette,
		sub_color, output ready);
endinterface

interface wccm_out_if;
	import wccm_pkg::*;

	logic               valid;
	logic               ready;
	logic [COLOR_W-1:0] out_color;
	logic [MASK_W-1:0]  main_window_mask;
	logic [MASK_W-1:0]  sub_window_mask;

	modport source (output valid, out_color, main_window_mask, sub_window_mask,
		input ready);
	modport sink (input valid, out_color, main_window_mask, sub_window_mask,
		output ready);
endinterface

/* hdl/wccm_cfg.sv */
module wccm_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [wccm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [wccm_pkg::CFG_DATA_W-1:0]  cfg_data,
	output wccm_pkg::cfg_t                   cfg
);
	import wccm_pkg::*;

	cfg_t cfg_q;

	// register file, writes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WINDOW_EDGES:        cfg_q.window_edges         <= cfg_data;
				REG_WINDOW_SELECT:       cfg_q.window_select        <= cfg_data[23:0];
				REG_WINDOW_LOGIC:        cfg_q.window_logic         <= cfg_data[15:0];
				REG_WINDOW_LAYER_ENABLE: cfg_q.window_layer_enable  <= cfg_data[15:0];
				REG_COLOR_WINDOW_CTRL:   cfg_q.color_window_control <= cfg_data[7:0];
				REG_COLOR_MATH_CTRL:     cfg_q.color_math_control   <= cfg_data[7:0];
				REG_FIXED_COLOR:         cfg_q.fixed_color          <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

/* hdl/wccm_window.sv */
module wccm_window (
	input  wccm_pkg::cfg_t                  cfg,
	input  logic [wccm_pkg::X_W-1:0]        x,
	output logic [wccm_pkg::SLOT_COUNT-1:0] win
);
	import wccm_pkg::*;

	logic [X_W-1:0] l1, r1, l2, r2;
	logic           in1, in2;

	assign l1 = cfg.window_edges[7:0];
	assign r1 = cfg.window_edges[15:8];
	assign l2 = cfg.window_edges[23:16];
	assign r2 = cfg.window_edges[31:24];

	// inclusive ranges, empty when left is past right
	assign in1 = (l1 <= r1) && (x >= l1) && (x <= r1);
	assign in2 = (l2 <= r2) && (x >= l2) && (x <= r2);

	// per slot enable, invert and combine
	always_comb begin
		logic [3:0] sel;
		logic [1:0] lg;
		logic       w1, w2;
		win = '0;
		for (int s = 0; s < SLOT_COUNT; s++) begin
			sel = cfg.window_select[4*s +: 4];
			lg  = cfg.window_logic[2*s +: 2];
			w1  = in1 ^ sel[0];
			w2  = in2 ^ sel[2];
			case ({sel[3], sel[1]})
				2'b00: win[s] = 1'b0;
				2'b01: win[s] = w1;
				2'b10: win[s] = w2;
				default: begin
					case (lg)
						LOGIC_OR:  win[s] = w1 | w2;
						LOGIC_AND: win[s] = w1 & w2;
						LOGIC_XOR: win[s] = w1 ^ w2;
						default:   win[s] = ~(w1 ^ w2);
					endcase
				end
			endcase
		end
	end
endmodule

/* hdl/wccm_blend.sv */
module wccm_blend (
	input  logic [wccm_pkg::COLOR_W-1:0] main_color,
	input  logic [wccm_pkg::COLOR_W-1:0] addend,
	input  logic                         subtract,
	input  logic                         half,
	output logic [wccm_pkg::COLOR_W-1:0] result
);
	import wccm_pkg::*;

	// per channel add or subtract, optional halve, clamp
	always_comb begin
		logic [CH_W-1:0] mc, ac;
		logic [CH_W:0]   v;
		result = '0;
		for (int ch = 0; ch < CH_COUNT; ch++) begin
			mc = main_color[CH_W*ch +: CH_W];
			ac = addend[CH_W*ch +: CH_W];
			if (subtract) begin
				v = (mc >= ac) ? {1'b0, mc - ac} : '0;
			end else begin
				v = {1'b0, mc} + {1'b0, ac};
			end
			if (half) begin
				v = v >> 1;
			end
			result[CH_W*ch +: CH_W] = v[CH_W] ? CH_MAX : v[CH_W-1:0];
		end
	end
endmodule

/* hdl/window_clip_and_color_math_unit.sv */
// window masks, color window clipping and color math, one pixel per item
// stages: input register, then result register
// throughput: one item per cycle; the input stage stalls only while a result waits
// reset: arst_n clears both stage valids and all configuration registers to zero
module window_clip_and_color_math_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	wccm_in_if.sink                          pix_in,
	wccm_out_if.source                       pix_out,
	input  logic                             cfg_we,
	input  logic [wccm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [wccm_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import wccm_pkg::*;

	cfg_t cfg;

	logic               valid_s1;
	logic [X_W-1:0]     x_s1;
	logic [COLOR_W-1:0] mcol_s1;
	logic [LAYER_W-1:0] layer_s1;
	logic [PAL_W-1:0]   pal_s1;
	logic [COLOR_W-1:0] scol_s1;

	logic               valid_s2;
	logic [COLOR_W-1:0] color_s2;
	logic [MASK_W-1:0]  mmask_s2;
	logic [MASK_W-1:0]  smask_s2;

	logic                  go_s1;
	logic [SLOT_COUNT-1:0] win;
	logic                  clip, prevent, math, sub_sel;
	logic [COLOR_W-1:0]    mcol_clip, addend, blended, result;
	logic [MASK_W-1:0]     mmask, smask;

	wccm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// handshake: stage one moves when the result register is free or drained
	assign go_s1        = valid_s1 && (!valid_s2 || pix_out.ready);
	assign pix_in.ready = !valid_s1 || go_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_in.ready) begin
			valid_s1 <= pix_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_in.ready && pix_in.valid) begin
			x_s1     <= pix_in.pixel_x;
			mcol_s1  <= pix_in.main_color;
			layer_s1 <= pix_in.main_layer;
			pal_s1   <= pix_in.main_obj_palette;
			scol_s1  <= pix_in.sub_color;
		end
	end

	wccm_window u_window (
		.cfg (cfg),
		.x   (x_s1),
		.win (win)
	);

	// layer masks per screen
	assign mmask = win[MASK_W-1:0] & cfg.window_layer_enable[MASK_W-1:0];
	assign smask = win[MASK_W-1:0] & cfg.window_layer_enable[8 +: MASK_W];

	// clip and prevent regions from the color window
	assign clip      = region_active(cfg.color_window_control[7:6], win[SLOT_COLOR]);
	assign prevent   = region_active(cfg.color_window_control[5:4], win[SLOT_COLOR]);
	assign sub_sel   = cfg.color_window_control[1];
	assign mcol_clip = clip ? '0 : mcol_s1;

	// math enable by source layer, objects only for the upper palettes
	always_comb begin
		case (layer_s1) inside
			[3'd0:LAYER_BG_LAST]: math = cfg.color_math_control[layer_s1[1:0]];
			LAYER_OBJ:            math = (pal_s1 >= PAL_MATH_MIN) && cfg.color_math_control[4];
			default:              math = cfg.color_math_control[5];
		endcase
	end

	assign addend = sub_sel ? scol_s1 : cfg.fixed_color;

	wccm_blend u_blend (
		.main_color (mcol_clip),
		.addend     (addend),
		.subtract   (cfg.color_math_control[7]),
		.half       (cfg.color_math_control[6]),
		.result     (blended)
	);

	assign result = (!math || (sub_sel && prevent)) ? mcol_clip : blended;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (go_s1) begin
			valid_s2 <= 1'b1;
		end else if (pix_out.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1) begin
			color_s2 <= result;
			mmask_s2 <= mmask;
			smask_s2 <= smask;
		end
	end

	assign pix_out.valid            = valid_s2;
	assign pix_out.out_color        = color_s2;
	assign pix_out.main_window_mask = mmask_s2;
	assign pix_out.sub_window_mask  = smask_s2;
endmodule

/* hdl/wccm_checker.sv */
module wccm_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [wccm_pkg::COLOR_W-1:0] out_color,
	input logic [wccm_pkg::MASK_W-1:0]  main_window_mask,
	input logic [wccm_pkg::MASK_W-1:0]  sub_window_mask
);
	import wccm_pkg::*;

	// a waiting result stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a waiting result holds its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_color) && $stable(main_window_mask)
			&& $stable(sub_window_mask))
		else $error("result payload changed while stalled");

	// a draining output always frees the input side
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output drains");

	// an accepted item leads to a valid result on the output
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> ##1 out_valid)
		else $error("accepted item produced no result");
endmodule

bind window_clip_and_color_math_unit wccm_checker u_wccm_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (pix_in.valid),
	.in_ready         (pix_in.ready),
	.out_valid        (pix_out.valid),
	.out_ready        (pix_out.ready),
	.out_color        (pix_out.out_color),
	.main_window_mask (pix_out.main_window_mask),
	.sub_window_mask  (pix_out.sub_window_mask)
);

/* tb/sv/window_clip_and_color_math_unit_test.sv */
`timescale 1ns / 100ps

import wccm_pkg::*;

// one pixel offered to the block
typedef struct packed {
	logic [X_W-1:0]     x;
	logic [COLOR_W-1:0] main_color;
	logic [LAYER_W-1:0] main_layer;
	logic [PAL_W-1:0]   main_obj_palette;
	logic [COLOR_W-1:0] sub_color;
} pixel_in_t;

// one finished pixel from the block
typedef struct packed {
	logic [COLOR_W-1:0] color;
	logic [MASK_W-1:0]  main_mask;
	logic [MASK_W-1:0]  sub_mask;
} pixel_out_t;

// control bit positions
localparam int MATH_SUB_BIT      = 7;
localparam int MATH_HALF_BIT     = 6;
localparam int MATH_BACKDROP_BIT = 5;
localparam int MATH_OBJ_BIT      = 4;
localparam int CWIN_SUB_SEL_BIT  = 1;
localparam int SUB_ENABLE_BASE   = 8;

// keeps the expected pixels in order and compares finished ones against them
class pixel_color_board;
	pixel_out_t expected_q[$];
	int errors;
	int results_seen;

	function new();
		errors = 0;
		results_seen = 0;
	endfunction

	function bit window_hit(bit en, bit inv, logic [7:0] left, logic [7:0] right,
		logic [7:0] x);
		bit hit;
		if (!en)
			return 1'b0;
		hit = (left <= right) && (x >= left) && (x <= right);
		return inv ? !hit : hit;
	endfunction

	// combined window of one slot: backgrounds, objects or color window
	function bit slot_window(cfg_t c, int slot, logic [7:0] x);
		logic [3:0] sel;
		logic [1:0] lg;
		bit e1, e2, w1, w2, res;
		sel = c.window_select[4*slot +: 4];
		lg = c.window_logic[2*slot +: 2];
		e1 = sel[1];
		e2 = sel[3];
		w1 = window_hit(e1, sel[0], c.window_edges[7:0], c.window_edges[15:8], x);
		w2 = window_hit(e2, sel[2], c.window_edges[23:16], c.window_edges[31:24], x);
		if (!e1 && !e2)
			res = 1'b0;
		else if (e1 && !e2)
			res = w1;
		else if (!e1 && e2)
			res = w2;
		else begin
			case (lg)
				LOGIC_OR:  res = w1 | w2;
				LOGIC_AND: res = w1 & w2;
				LOGIC_XOR: res = w1 ^ w2;
				default:   res = !(w1 ^ w2);
			endcase
		end
		return res;
	endfunction

	function bit region_on(logic [1:0] code, bit in_win);
		bit on;
		case (code)
			REGION_NEVER:   on = 1'b0;
			REGION_OUTSIDE: on = !in_win;
			REGION_INSIDE:  on = in_win;
			default:        on = 1'b1;
		endcase
		return on;
	endfunction

	// per-channel add or subtract with optional halving and clamp
	function logic [COLOR_W-1:0] mix_color(cfg_t c, logic [COLOR_W-1:0] m,
		logic [COLOR_W-1:0] a);
		logic [COLOR_W-1:0] res;
		int mc, ac, v;
		res = '0;
		for (int ch = 0; ch < CH_COUNT; ch++) begin
			mc = int'(m[CH_W*ch +: CH_W]);
			ac = int'(a[CH_W*ch +: CH_W]);
			if (c.color_math_control[MATH_SUB_BIT])
				v = (mc >= ac) ? mc - ac : 0;
			else
				v = mc + ac;
			if (c.color_math_control[MATH_HALF_BIT])
				v = v >> 1;
			if (v > int'(CH_MAX))
				v = int'(CH_MAX);
			res[CH_W*ch +: CH_W] = v[CH_W-1:0];
		end
		return res;
	endfunction

	function pixel_out_t predict(cfg_t c, pixel_in_t p);
		pixel_out_t r;
		logic [COLOR_W-1:0] mcol;
		bit w, in_cwin, math;
		r = '0;
		for (int l = 0; l < MASK_W; l++) begin
			w = slot_window(c, l, p.x);
			r.main_mask[l] = w & c.window_layer_enable[l];
			r.sub_mask[l] = w & c.window_layer_enable[SUB_ENABLE_BASE + l];
		end
		in_cwin = slot_window(c, SLOT_COLOR, p.x);
		mcol = p.main_color;
		if (region_on(c.color_window_control[7:6], in_cwin))
			mcol = '0;
		if (p.main_layer <= LAYER_BG_LAST)
			math = c.color_math_control[p.main_layer];
		else if (p.main_layer == LAYER_OBJ)
			math = (p.main_obj_palette >= PAL_MATH_MIN) && c.color_math_control[MATH_OBJ_BIT];
		else
			math = c.color_math_control[MATH_BACKDROP_BIT];
		if (!math)
			r.color = mcol;
		else if (c.color_window_control[CWIN_SUB_SEL_BIT]) begin
			if (region_on(c.color_window_control[5:4], in_cwin))
				r.color = mcol;
			else
				r.color = mix_color(c, mcol, p.sub_color);
		end else
			r.color = mix_color(c, mcol, c.fixed_color);
		return r;
	endfunction

	function void note_pixel(cfg_t c, pixel_in_t p);
		expected_q.push_back(predict(c, p));
	endfunction

	function void check_result(pixel_out_t got);
		pixel_out_t want;
		results_seen++;
		if (expected_q.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected pixel %0d: color %h main %b sub %b", results_seen,
					got.color, got.main_mask, got.sub_mask);
			return;
		end
		want = expected_q.pop_front();
		if (got.color !== want.color || got.main_mask !== want.main_mask ||
			got.sub_mask !== want.sub_mask) begin
			errors++;
			if (errors <= 10)
				$display({"pixel %0d: color exp %h got %h, ",
					"main mask exp %b got %b, sub mask exp %b got %b"},
					results_seen, want.color, got.color, want.main_mask, got.main_mask,
					want.sub_mask, got.sub_mask);
		end
	endfunction

	function int pending();
		return expected_q.size();
	endfunction
endclass

module window_clip_and_color_math_unit_test;

	localparam int RESET_CYCLES    = 11;
	localparam int HOLD_CYCLES     = 400;
	localparam int STALL_LIMIT     = 4000;
	localparam int PHASES          = 13;
	localparam int ITEMS_PER_PHASE = 110;

	localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;

	localparam logic [LAYER_W-1:0] LAYER_BG0      = 3'd0;
	localparam logic [LAYER_W-1:0] LAYER_BG1      = 3'd1;
	localparam logic [LAYER_W-1:0] LAYER_BG2      = 3'd2;
	localparam logic [LAYER_W-1:0] LAYER_BACKDROP = 3'd5;
	localparam logic [LAYER_W-1:0] LAYER_ALIAS6   = 3'd6;
	localparam logic [LAYER_W-1:0] LAYER_ALIAS7   = 3'd7;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	wccm_in_if pix_in();
	wccm_out_if pix_out();

	window_clip_and_color_math_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_in    (pix_in),
		.pix_out   (pix_out),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pixel_color_board board = new();
	cfg_t cfg_cur;
	bit quiet = 1'b0;
	bit hold_request = 1'b0;
	int stall_cycles = 0;

	always #4 clk = ~clk;

	// register write, model copy follows the register
	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_WINDOW_EDGES:        cfg_cur.window_edges = data;
			REG_WINDOW_SELECT:       cfg_cur.window_select = data[23:0];
			REG_WINDOW_LOGIC:        cfg_cur.window_logic = data[15:0];
			REG_WINDOW_LAYER_ENABLE: cfg_cur.window_layer_enable = data[15:0];
			REG_COLOR_WINDOW_CTRL:   cfg_cur.color_window_control = data[7:0];
			REG_COLOR_MATH_CTRL:     cfg_cur.color_math_control = data[7:0];
			REG_FIXED_COLOR:         cfg_cur.fixed_color = data[14:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// write every register, junk in the unused upper bits
	task automatic apply_cfg(cfg_t c);
		logic [CFG_DATA_W-1:0] d;
		d = c.window_edges;
		write_reg(REG_WINDOW_EDGES, d);
		d = $urandom();
		d[23:0] = c.window_select;
		write_reg(REG_WINDOW_SELECT, d);
		d = $urandom();
		d[15:0] = c.window_logic;
		write_reg(REG_WINDOW_LOGIC, d);
		d = $urandom();
		d[15:0] = c.window_layer_enable;
		write_reg(REG_WINDOW_LAYER_ENABLE, d);
		d = $urandom();
		d[7:0] = c.color_window_control;
		write_reg(REG_COLOR_WINDOW_CTRL, d);
		d = $urandom();
		d[7:0] = c.color_math_control;
		write_reg(REG_COLOR_MATH_CTRL, d);
		d = $urandom();
		d[14:0] = c.fixed_color;
		write_reg(REG_FIXED_COLOR, d);
	endtask

	function automatic cfg_t random_cfg();
		cfg_t c;
		logic [7:0] a, b;
		c.window_edges = $urandom();
		// mostly well-formed windows, some empty ones
		for (int w = 0; w < 2; w++) begin
			a = c.window_edges[16*w +: 8];
			b = c.window_edges[16*w+8 +: 8];
			if ($urandom_range(0, 3) != 0 && a > b) begin
				c.window_edges[16*w +: 8] = b;
				c.window_edges[16*w+8 +: 8] = a;
			end
		end
		c.window_select = 24'($urandom());
		c.window_logic = 16'($urandom());
		c.window_layer_enable = 16'($urandom());
		c.color_window_control = 8'($urandom());
		c.color_math_control = 8'($urandom());
		case ($urandom_range(0, 3))
			0: c.fixed_color = '0;
			1: c.fixed_color = '1;
			default: c.fixed_color = 15'($urandom());
		endcase
		return c;
	endfunction

	function automatic logic [COLOR_W-1:0] random_color();
		logic [COLOR_W-1:0] col;
		case ($urandom_range(0, 7))
			0: col = '0;
			1: col = '1;
			2: begin
				for (int ch = 0; ch < CH_COUNT; ch++)
					col[CH_W*ch +: CH_W] = $urandom_range(0, 1) ? CH_MAX : '0;
			end
			default: col = 15'($urandom());
		endcase
		return col;
	endfunction

	// columns cluster around the window edges
	function automatic pixel_in_t random_pixel();
		pixel_in_t p;
		logic [7:0] e;
		e = cfg_cur.window_edges[8*$urandom_range(0, 3) +: 8];
		if ($urandom_range(0, 1))
			p.x = 8'($urandom());
		else
			p.x = e + 8'($urandom_range(0, 2)) - 8'd1;
		p.main_color = random_color();
		p.main_layer = 3'($urandom_range(0, 7));
		p.main_obj_palette = 3'($urandom_range(0, 7));
		p.sub_color = random_color();
		return p;
	endfunction

	// offer one item, with an occasional gap before it
	task automatic send_pixel(pixel_in_t p);
		bit took;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			pix_in.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		pix_in.valid <= 1'b1;
		pix_in.pixel_x <= p.x;
		pix_in.main_color <= p.main_color;
		pix_in.main_layer <= p.main_layer;
		pix_in.main_obj_palette <= p.main_obj_palette;
		pix_in.sub_color <= p.sub_color;
		do begin
			@(negedge clk);
			took = pix_in.ready;
			@(posedge clk);
		end while (!took);
		board.note_pixel(cfg_cur, p);
	endtask

	// stop offering and let the pipeline empty
	task automatic settle_idle();
		pix_in.valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// result side: random stalls and one long hold-off
	initial begin
		pix_out.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				pix_out.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
				pix_out.ready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				pix_out.ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				pix_out.ready <= 1'b1;
			end else
				pix_out.ready <= 1'b1;
		end
	end

	// result check, sampled mid-cycle where handshake signals are settled
	always @(negedge clk) begin
		if (arst_n && pix_out.valid && pix_out.ready)
			board.check_result('{pix_out.out_color, pix_out.main_window_mask,
				pix_out.sub_window_mask});
	end

	// watchdog on cycles without any accepted item
	always @(negedge clk) begin
		if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready))
			stall_cycles = 0;
		else
			stall_cycles = stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// stimulus
	initial begin
		cfg_t c;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		pix_in.valid = 1'b0;
		pix_in.pixel_x = '0;
		pix_in.main_color = '0;
		pix_in.main_layer = '0;
		pix_in.main_obj_palette = '0;
		pix_in.sub_color = '0;
		cfg_cur = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every combine code, clip inside color window, fixed add
		c.window_edges = {8'd30, 8'd15, 8'd20, 8'd10};
		c.window_select = {4'hB, 4'h2, 4'hA, 4'hA, 4'hA, 4'hA};
		c.window_logic = {4'b0000, LOGIC_AND, LOGIC_XNOR, LOGIC_XNOR, LOGIC_XOR, LOGIC_AND,
			LOGIC_OR};
		c.window_layer_enable = 16'h1f1f;
		c.color_window_control = {REGION_INSIDE, REGION_NEVER, 4'b0000};
		c.color_math_control = 8'h3f;
		c.fixed_color = {5'd31, 5'd16, 5'd1};
		apply_cfg(c);
		send_pixel('{8'd0, 15'h7fff, LAYER_BG0, 3'd0, 15'h0000});
		send_pixel('{8'd9, 15'h0000, LAYER_BG1, 3'd7, 15'h7fff});
		send_pixel('{8'd10, 15'h4210, LAYER_BG2, 3'd0, 15'h7fff});
		send_pixel('{8'd15, 15'h7fff, LAYER_BG_LAST, 3'd0, 15'h0000});
		send_pixel('{8'd20, 15'h7fff, LAYER_OBJ, 3'd3, 15'h0000});
		send_pixel('{8'd21, 15'h7fff, LAYER_OBJ, 3'd4, 15'h0000});
		send_pixel('{8'd25, 15'h7fff, LAYER_BG0, 3'd0, 15'h7fff});
		send_pixel('{8'd30, 15'h1234, LAYER_BACKDROP, 3'd0, 15'h0000});
		send_pixel('{8'd31, 15'h2345, LAYER_ALIAS6, 3'd0, 15'h0000});
		send_pixel('{8'd255, 15'h7fff, LAYER_ALIAS7, 3'd7, 15'h7fff});
		send_pixel('{8'd18, 15'h03e0, LAYER_OBJ, 3'd7, 15'h0000});
		settle_idle();

		// directed: sub color, prevent outside, subtract and halve, empty window
		c.window_edges = {8'd30, 8'd40, 8'd100, 8'd50};
		c.window_select = {4'h2, 4'h3, 4'hF, 4'h0, 4'h8, 4'hC};
		c.window_logic = {4'b0000, LOGIC_OR, LOGIC_AND, LOGIC_XNOR, LOGIC_XOR, LOGIC_AND,
			LOGIC_OR};
		c.window_layer_enable = 16'h1b15;
		c.color_window_control = {REGION_NEVER, REGION_OUTSIDE, 2'b00, 1'b1, 1'b0};
		c.color_math_control = 8'hff;
		c.fixed_color = '0;
		apply_cfg(c);
		send_pixel('{8'd0, 15'h7fff, LAYER_BG0, 3'd0, 15'h0000});
		send_pixel('{8'd49, 15'h0000, LAYER_BG1, 3'd0, 15'h7fff});
		send_pixel('{8'd50, 15'h7fff, LAYER_BG2, 3'd0, 15'h0000});
		send_pixel('{8'd75, 15'h4a52, LAYER_BG_LAST, 3'd0, 15'h7fff});
		send_pixel('{8'd100, 15'h7fff, LAYER_OBJ, 3'd4, 15'h0421});
		send_pixel('{8'd101, 15'h7fff, LAYER_OBJ, 3'd5, 15'h0421});
		send_pixel('{8'd35, 15'h56b5, LAYER_BACKDROP, 3'd0, 15'h7fff});
		send_pixel('{8'd128, 15'h1111, LAYER_ALIAS7, 3'd0, 15'h0000});
		send_pixel('{8'd255, 15'h7fff, LAYER_OBJ, 3'd3, 15'h7fff});
		settle_idle();

		// random phases, extremes first
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: c = '0;
				1: c = '1;
				2: begin
					c = random_cfg();
					c.window_edges = 32'hff00ff00;
				end
				default: c = random_cfg();
			endcase
			if (phase == 3)
				write_reg(REG_SPARE, $urandom());
			apply_cfg(c);
			quiet = (phase >= PHASES - 2);
			if (phase == 4)
				hold_request = 1'b1;
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				// once, let every result come home before going on
				if (phase == 6 && i == ITEMS_PER_PHASE / 2) begin
					pix_in.valid <= 1'b0;
					do
						@(posedge clk);
					while (board.pending() != 0);
				end
				send_pixel(random_pixel());
			end
			settle_idle();
		end

		repeat (8) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
